// ----- src/srec_pkg.sv -----
// Shared types, constants and helpers for the S-record S3 encoder.
// No dependencies; imported by every module of the block but srec_ram.
`timescale 1ns / 1ps

package srec_pkg;

  // Default chunk size in bytes (one S3 record at most)
  localparam int DEF_CHUNK_BYTES = 32;

  // ASCII characters of the record header
  localparam logic [6:0] CHAR_S  = 7'h53;
  localparam logic [6:0] CHAR_3  = 7'h33;
  localparam logic [6:0] CHAR_7  = 7'h37;

  // Fixed bytes
  localparam logic [7:0] BYTE_FF      = 8'hFF;
  localparam logic [7:0] COUNT_EXTRA  = 8'h05;
  localparam logic [7:0] S7_COUNT     = 8'h05;
  localparam logic [7:0] S7_CSUM      = 8'hFA;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       end_of_stream;
  } in_word_t;

  // Result word: one character pair
  typedef struct packed {
    logic [6:0] char_first;
    logic [6:0] char_second;
    logic       line_end;
    logic       last;
  } out_word_t;

  // Pair handed from the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } emit_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_HDR,
    ST_CNT,
    ST_ADDR,
    ST_RD,
    ST_DAT,
    ST_CSUM,
    ST_S7HDR,
    ST_S7BODY
  } seq_state_t;

  // Upper-case ASCII hex digit of a nibble
  function automatic logic [6:0] hex_digit(input logic [3:0] v);
    logic [6:0] c;
    if (v < 4'd10) begin
      c = 7'h30 + {3'b000, v};
    end else begin
      c = 7'h37 + {3'b000, v};
    end
    return c;
  endfunction

endpackage

// ----- src/srecord_s3_encoder_core.sv -----
// A word that flushes a chunk of n bytes goes through ST_LOAD to ST_HDR, whose pair is first
// into the output register; the S3 record has n+7 pairs, each data pair read from the chunk
// RAM in ST_RD; at end of stream the S7 record adds 7. A buffer-only word leaves in_stall
// low; else it is high from acceptance until the final pair enters the output register.
// Reset (synchronous, rst_n low) empties the chunk, zeroes offset and start address.
// Top level: config register, sequencer and output register. Depends on srec_pkg, srec_ctrl.
`timescale 1ns / 1ps

module srecord_s3_encoder_core
  import srec_pkg::*;
#(
  parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  in_word_t    in_word,
  output logic        in_stall,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        out_stall
);

  logic [31:0] start_addr_r;
  logic        out_valid_r;
  out_word_t   out_word_r;
  logic        go;
  emit_t       emit;

  // Start address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= '0;
    end else if (cfg_we) begin
      start_addr_r <= cfg_wdata;
    end
  end

  // Output slot free or being taken
  assign go = !out_valid_r || !out_stall;

  srec_ctrl #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .in_stall   (in_stall),
    .start_addr (start_addr_r),
    .go         (go),
    .emit       (emit)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_word_r <= emit.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- src/srec_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/srec_ctrl.sv -----
// Record sequencer: chunk buffer in RAM, running sum, offset and pair generation.
// Depends on srec_pkg and srec_ram.
`timescale 1ns / 1ps

module srec_ctrl
  import srec_pkg::*;
#(
  parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  in_word_t    in_word,
  output logic        in_stall,
  input  logic [31:0] start_addr,
  input  logic        go,
  output emit_t       emit
);

  localparam int AW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int FW = $clog2(CHUNK_BYTES + 1);

  seq_state_t    state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [31:0]   offset_r, offset_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [7:0]    csum_r, csum_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          eos_r, eos_nxt;

  logic          acc;
  logic [FW-1:0] fill_in;
  logic          flush_now;
  logic          last_data;
  logic [7:0]    count_byte;
  logic [7:0]    rd_byte;
  logic          ram_we;
  logic          ram_re;

  // Input side
  assign in_stall  = (state_r != ST_IDLE);
  assign acc       = in_valid && (state_r == ST_IDLE);
  assign fill_in   = fill_r + FW'(in_word.has_data);
  assign flush_now = (in_word.has_data && (fill_in == FW'(CHUNK_BYTES)))
                  || (in_word.end_of_stream && (fill_in != '0));
  assign ram_we    = acc && in_word.has_data;
  assign ram_re    = (state_r == ST_RD);
  assign last_data = ((FW'(idx_r) + FW'(1)) == fill_r);
  assign count_byte = 8'(fill_r) + COUNT_EXTRA;

  // Chunk buffer; writes only in idle, reads only while flushing
  srec_ram #(
    .WIDTH (8),
    .DEPTH (CHUNK_BYTES)
  ) u_chunk (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(fill_r)),
    .wdata (in_word.data_byte),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (rd_byte)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (flush_now) begin
            state_nxt = ST_LOAD;
          end else if (in_word.end_of_stream) begin
            state_nxt = ST_S7HDR;
          end
        end
      end
      ST_LOAD:  state_nxt = ST_HDR;
      ST_HDR:   if (go) state_nxt = ST_CNT;
      ST_CNT:   if (go) state_nxt = ST_ADDR;
      ST_ADDR:  if (go && cnt_r == 3'd3) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_DAT;
      ST_DAT: begin
        if (go) begin
          state_nxt = last_data ? ST_CSUM : ST_RD;
        end
      end
      ST_CSUM: begin
        if (go) begin
          state_nxt = eos_r ? ST_S7HDR : ST_IDLE;
        end
      end
      ST_S7HDR:  if (go) state_nxt = ST_S7BODY;
      ST_S7BODY: if (go && cnt_r == 3'd5) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Pair output
  always_comb begin
    logic [7:0] b;
    b = BYTE_ZERO;
    emit = '0;
    case (state_r)
      ST_HDR: begin
        emit.valid = 1'b1;
        emit.word.char_first  = CHAR_S;
        emit.word.char_second = CHAR_3;
      end
      ST_S7HDR: begin
        emit.valid = 1'b1;
        emit.word.char_first  = CHAR_S;
        emit.word.char_second = CHAR_7;
      end
      ST_CNT, ST_ADDR, ST_DAT, ST_CSUM, ST_S7BODY: begin
        case (state_r)
          ST_CNT:  b = count_byte;
          ST_ADDR: b = addr_r[8*(3 - int'(cnt_r[1:0])) +: 8];
          ST_DAT:  b = rd_byte;
          ST_CSUM: b = csum_r;
          default: begin
            if (cnt_r == 3'd0) begin
              b = S7_COUNT;
            end else if (cnt_r == 3'd5) begin
              b = S7_CSUM;
            end else begin
              b = BYTE_ZERO;
            end
          end
        endcase
        emit.valid = 1'b1;
        emit.word.char_first  = hex_digit(b[7:4]);
        emit.word.char_second = hex_digit(b[3:0]);
        if (state_r == ST_CSUM) begin
          emit.word.line_end = 1'b1;
          emit.word.last     = !eos_r;
        end else if (state_r == ST_S7BODY && cnt_r == 3'd5) begin
          emit.word.line_end = 1'b1;
          emit.word.last     = 1'b1;
        end
      end
      default: emit = '0;
    endcase
  end

  // Datapath next values
  always_comb begin
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    offset_nxt = offset_r;
    addr_nxt   = addr_r;
    csum_nxt   = csum_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    eos_nxt    = eos_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          eos_nxt = in_word.end_of_stream;
          if (in_word.has_data) begin
            fill_nxt = fill_in;
            sum_nxt  = sum_r + in_word.data_byte;
          end
        end
      end
      ST_LOAD: addr_nxt = start_addr + offset_r;
      ST_HDR: begin
        cnt_nxt  = '0;
        csum_nxt = BYTE_FF - (count_byte + addr_r[31:24] + addr_r[23:16]
                              + addr_r[15:8] + addr_r[7:0] + sum_r);
      end
      ST_ADDR: begin
        if (go) begin
          cnt_nxt = cnt_r + 3'd1;
          idx_nxt = '0;
        end
      end
      ST_DAT: begin
        if (go && !last_data) begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_CSUM: begin
        if (go) begin
          offset_nxt = offset_r + 32'(fill_r);
          fill_nxt   = '0;
          sum_nxt    = '0;
        end
      end
      ST_S7HDR: cnt_nxt = '0;
      ST_S7BODY: begin
        if (go) begin
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd5) begin
            offset_nxt = '0;
            fill_nxt   = '0;
            sum_nxt    = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      sum_r    <= '0;
      offset_r <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
      eos_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      sum_r    <= sum_nxt;
      offset_r <= offset_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      eos_r    <= eos_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    csum_r <= csum_nxt;
  end

endmodule

// ----- src/srec_chk.sv -----
// Port-level checker for the S-record encoder, bound to the top level.
// Depends on srec_pkg and srecord_s3_encoder_core.
`timescale 1ns / 1ps

module srec_chk
  import srec_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input out_word_t out_word,
  input logic      out_stall
);

  // Stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // A word that is not the last of its item means the item is still in work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |-> in_stall)
    else $error("input taken before item finished");

  // The last word of an item always closes a record
  a_last_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |-> out_word.line_end)
    else $error("last word without line end");

  // A record header never ends a line
  a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.char_first == CHAR_S) |-> !out_word.line_end && !out_word.last)
    else $error("header pair flagged as line end");

endmodule

bind srecord_s3_encoder_core srec_chk u_srec_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_word  (out_word),
  .out_stall (out_stall)
);

// ----- tb/testbench.sv -----
// Testbench for srecord_s3_encoder_core: random and directed byte streams in, ASCII pairs out.
// A built-in S-record encoder predicts every pair, which is checked in order.
// Depends on srec_pkg and srecord_s3_encoder_core.
`timescale 1ns / 1ps

module testbench;
  import srec_pkg::*;

  localparam int CHUNK = DEF_CHUNK_BYTES;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  in_word_t    in_word = '0;
  logic        in_stall;
  logic        out_valid;
  out_word_t   out_word;
  logic        out_stall = 1'b0;

  // Input words waiting for the driver, and pairs the encoder must still produce
  in_word_t  image_q[$];
  out_word_t pairs_due[$];

  // Encoder state as seen from outside
  logic [31:0] load_base = '0;
  logic [7:0]  chunk_buf[CHUNK];
  int          chunk_fill = 0;
  logic [31:0] emit_offset = '0;
  logic [7:0]  chunk_sum = '0;

  int words_queued = 0;
  int words_taken = 0;
  int pairs_seen = 0;
  int err_count = 0;

  // Handshake pacing
  int        tx_wait = 0;
  int        rx_wait = 0;
  int        hold_left = 0;
  bit        held_once = 1'b0;
  bit        tx_calm = 1'b0;
  bit        rx_calm = 1'b0;
  out_word_t want;

  srecord_s3_encoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("FAILURE");
    $finish;
  end

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Expected pair generation
  // ---------------------------------------------------------------------------
  function automatic logic [6:0] nib_char(logic [3:0] n);
    if (n > 4'd9) begin
      return 7'h41 + {3'b000, n - 4'd10};
    end
    return 7'h30 + {3'b000, n};
  endfunction

  task automatic put_pair(logic [6:0] a, logic [6:0] b, logic eol);
    out_word_t p;
    p.char_first  = a;
    p.char_second = b;
    p.line_end    = eol;
    p.last        = 1'b0;
    pairs_due.push_back(p);
  endtask

  task automatic put_hex(logic [7:0] v, logic eol);
    put_pair(nib_char(v[7:4]), nib_char(v[3:0]), eol);
  endtask

  task automatic put_addr(logic [31:0] a);
    put_hex(a[31:24], 1'b0);
    put_hex(a[23:16], 1'b0);
    put_hex(a[15:8], 1'b0);
    put_hex(a[7:0], 1'b0);
  endtask

  // S3 record of whatever the chunk holds; offset advances past it
  task automatic flush_record();
    logic [31:0] addr;
    logic [7:0]  cnt;
    logic [7:0]  csum;
    addr = load_base + emit_offset;
    cnt  = 8'(chunk_fill + 5);
    csum = cnt + addr[31:24] + addr[23:16] + addr[15:8] + addr[7:0] + chunk_sum;
    put_pair(CHAR_S, CHAR_3, 1'b0);
    put_hex(cnt, 1'b0);
    put_addr(addr);
    for (int i = 0; i < chunk_fill; i++) begin
      put_hex(chunk_buf[i], 1'b0);
    end
    put_hex(BYTE_FF - csum, 1'b1);
    emit_offset += 32'(chunk_fill);
    chunk_fill = 0;
    chunk_sum = '0;
  endtask

  task automatic encode_word(in_word_t w);
    int        n0;
    out_word_t tail;
    n0 = pairs_due.size();
    if (w.has_data) begin
      if (chunk_fill < CHUNK) begin
        chunk_buf[chunk_fill] = w.data_byte;
        chunk_fill++;
        chunk_sum += w.data_byte;
      end
      if (chunk_fill >= CHUNK) begin
        flush_record();
      end
    end
    // end of stream: pending record, then the fixed S7 trailer
    if (w.end_of_stream) begin
      if (chunk_fill > 0) begin
        flush_record();
      end
      put_pair(CHAR_S, CHAR_7, 1'b0);
      put_hex(S7_COUNT, 1'b0);
      put_addr(32'h0);
      put_hex(BYTE_FF - S7_COUNT, 1'b1);
      chunk_fill = 0;
      emit_offset = '0;
      chunk_sum = '0;
    end
    // mark the final pair this word caused
    if (pairs_due.size() > n0) begin
      tail = pairs_due.pop_back();
      tail.last = 1'b1;
      pairs_due.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one word per handshake, random gap after each accepted word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_word(in_word);
        words_taken++;
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        tx_wait = tx_calm ? 0 : $urandom_range(0, 16);
      end
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (image_q.size() > 0) begin
          in_valid <= 1'b1;
          in_word <= image_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long back-pressure while the sender still has words to offer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!held_once && pairs_seen >= 300 && words_taken < words_queued) begin
      hold_left <= 500;
      held_once <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each pair, random stall after each
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        pairs_seen++;
        if (pairs_due.size() == 0) begin
          flag_error($sformatf("unexpected pair '%c%c' eol=%0b last=%0b",
                               out_word.char_first, out_word.char_second,
                               out_word.line_end, out_word.last));
        end else begin
          want = pairs_due.pop_front();
          if (out_word !== want) begin
            flag_error($sformatf("pair %0d: got '%c%c' %0b/%0b, want '%c%c' %0b/%0b",
                                 pairs_seen, out_word.char_first, out_word.char_second,
                                 out_word.line_end, out_word.last, want.char_first,
                                 want.char_second, want.line_end, want.last));
          end
        end
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 16);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send(logic [7:0] b, logic has, logic eos);
    in_word_t w;
    w.data_byte     = b;
    w.has_data      = has;
    w.end_of_stream = eos;
    image_q.push_back(w);
    words_queued++;
  endtask

  // all words accepted, all pairs seen, then a wait so a buffer-only word settles
  task automatic drain();
    while (words_taken < words_queued || pairs_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_base(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    load_base = v;
  endtask

  initial begin
    int          made;
    int          len;
    bit          end_on_data;
    logic [31:0] base;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty stream, ignored word, byte with end, extreme bytes
    send(8'h00, 1'b0, 1'b1);
    send(8'hFF, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b1);
    send(8'hFF, 1'b1, 1'b0);
    send(8'h80, 1'b1, 1'b0);
    send(8'h7F, 1'b1, 1'b0);
    send(8'h01, 1'b1, 1'b0);
    send(8'h5A, 1'b0, 1'b0);
    send(8'hAA, 1'b1, 1'b1);
    send(8'hFF, 1'b1, 1'b1);
    // base changed while a chunk is partly filled
    send(8'h55, 1'b1, 1'b0);
    send(8'hA5, 1'b1, 1'b0);
    drain();
    set_base(32'hFFFF_FFFE);
    send(8'h3C, 1'b1, 1'b1);
    send(8'h12, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);
    drain();

    // random phases, each with its own base address
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: base = 32'h0000_0000;
        1: base = 32'hFFFF_FFFF;
        2: base = 32'hFFFF_FFE0;
        3: base = 32'hFFFF_FFF0;
        default: base = $urandom;
      endcase
      set_base(base);
      made = 0;
      while (made < 24) begin
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = 32;
          2: len = 64;
          3: len = $urandom_range(33, 63);
          default: len = $urandom_range(1, 31);
        endcase
        end_on_data = 1'($urandom_range(0, 1));
        // full chunk closed by its own last byte, and a stream that wraps
        if (made == 0 && ph == 1) begin
          len = 32;
          end_on_data = 1'b1;
        end else if (made == 0 && (ph == 2 || ph == 3)) begin
          len = 40;
        end
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) send(8'($urandom), 1'b0, 1'b0);
          send(8'($urandom), 1'b1, end_on_data && i == len - 1);
        end
        if (!end_on_data || len == 0) begin
          send(8'($urandom), 1'b0, 1'b1);
        end
        made += len + 1;
      end
      // sometimes leave a stream open across the base change
      if ($urandom_range(0, 1) == 1) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          send(8'($urandom), 1'b1, 1'b0);
        end
      end
      drain();
    end
    send(8'($urandom), 1'b0, 1'b1);
    drain();

    if (pairs_due.size() > 0) begin
      flag_error($sformatf("%0d pairs never produced", pairs_due.size()));
    end
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
